// ===== src/b64d_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_pkg
// Types, constants and the alphabet lookup shared by the Base64 stream
// decoder modules.
// ----------------------------------------------------------------------------
package b64d_pkg;

  // Field widths
  localparam int CHAR_W  = 8;
  localparam int CNT_W   = 16;
  localparam int SLOTS   = 4;

  // Register reset value
  localparam logic [CNT_W-1:0] CAP_RESET = 16'd1024;

  // Status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Lookup codes for non-alphabet characters
  localparam logic [7:0] SX_PAD = 8'd64;
  localparam logic [7:0] SX_BAD = 8'd255;

  // Characters with special meaning
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_SPACE = 8'd32;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_SLASH = 8'd47;
  localparam logic [7:0] CH_EQUAL = 8'd61;

  // Sextet values of the last two alphabet characters and first digit
  localparam logic [7:0] SX_PLUS  = 8'd62;
  localparam logic [7:0] SX_SLASH = 8'd63;
  localparam logic [7:0] SX_DIGIT = 8'd52;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic              end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0]       data_byte;
    logic [1:0]       status;
    logic [CNT_W-1:0] byte_count;
    logic             last;
  } res_item_t;

  // Group of results caused by one request
  typedef struct packed {
    res_item_t [SLOTS-1:0] slot;
    logic [2:0]            cnt;
  } batch_t;

  // Map a character to its sextet, SX_PAD for '=' or SX_BAD otherwise
  function automatic logic [7:0] sextet_of(input logic [7:0] ch);
    logic [7:0] sx;
    sx = SX_BAD;
    if (ch >= 8'd65 && ch <= 8'd90) begin
      sx = ch - 8'd65;
    end else if (ch >= 8'd97 && ch <= 8'd122) begin
      sx = ch - 8'd71;
    end else if (ch >= 8'd48 && ch <= 8'd57) begin
      sx = ch - 8'd48 + SX_DIGIT;
    end else if (ch == CH_PLUS) begin
      sx = SX_PLUS;
    end else if (ch == CH_SLASH) begin
      sx = SX_SLASH;
    end else if (ch == CH_EQUAL) begin
      sx = SX_PAD;
    end
    return sx;
  endfunction

endpackage

// ===== src/b64d_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_in_if
// Character channel: valid/ready handshake carrying one text character or
// an end marker.
// ----------------------------------------------------------------------------
interface b64d_in_if;
  import b64d_pkg::*;

  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              end_of_text;

  modport source (output valid, output char_code, output end_of_text, input ready);
  modport sink   (input valid, input char_code, input end_of_text, output ready);
endinterface

// ===== src/b64d_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_out_if
// Result channel: valid/ready handshake carrying one decoded byte or the
// final status item of a string.
// ----------------------------------------------------------------------------
interface b64d_out_if;
  import b64d_pkg::*;

  logic             valid;
  logic             ready;
  logic [7:0]       data_byte;
  logic [1:0]       status;
  logic [CNT_W-1:0] byte_count;
  logic             last;

  modport source (output valid, output data_byte, output status, output byte_count,
                  output last, input ready);
  modport sink   (input valid, input data_byte, input status, input byte_count,
                  input last, output ready);
endinterface

// ===== src/base64_stream_decoder_top.sv =====
`timescale 1ns / 1ps
// Path: a request waits in the input register until the decode stage takes it; the
//   result register then holds its group of results and drives out_chan.
// Throughput: one character per cycle while the result register has room; it drains
//   a quartet's bytes one per cycle while out_chan is ready and new characters load.
// Reset (rst_n low, synchronous): clears quartet, error and count state and empty
//   flags; the output capacity register cap_r returns to 1024.
// ----------------------------------------------------------------------------
// base64_stream_decoder_top
// Streaming Base64 decoder: one character per request, decoded bytes and a
// final status item per string on the result channel.
// ----------------------------------------------------------------------------
module base64_stream_decoder_top #(
  parameter int COUNT_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst_n,
  b64d_in_if.sink                    in_chan,
  b64d_out_if.source                 out_chan,
  input  logic                       cfg_we,
  input  logic [b64d_pkg::CNT_W-1:0] cfg_wdata
);
  import b64d_pkg::*;

  logic [CNT_W-1:0] cap_r;
  logic             item_valid;
  in_item_t         item;
  logic             take;
  logic             load;
  logic             batch_done;
  batch_t           batch;

  // Output capacity register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= CAP_RESET;
    end else if (cfg_we) begin
      cap_r <= cfg_wdata;
    end
  end

  b64d_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_chan    (in_chan),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  b64d_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_decode (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .capacity   (cap_r),
    .batch_done (batch_done),
    .take       (take),
    .load       (load),
    .batch      (batch)
  );

  b64d_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (load),
    .batch      (batch),
    .batch_done (batch_done),
    .out_chan   (out_chan)
  );
endmodule

// ===== src/b64d_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_in_reg
// Input register: captures one request from the character channel and
// holds it until the decode stage takes it.
// ----------------------------------------------------------------------------
module b64d_in_reg (
  input  logic              clk,
  input  logic              rst_n,
  b64d_in_if.sink           in_chan,
  input  logic              take,
  output logic              item_valid,
  output b64d_pkg::in_item_t item
);
  import b64d_pkg::*;

  logic     valid_r;
  in_item_t item_r;
  logic     accept;

  // Accept when empty or when the held request leaves this cycle
  assign in_chan.ready = !valid_r || take;
  assign accept        = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Hold payload; no reset needed
  always_ff @(posedge clk) begin
    if (accept) begin
      item_r.char_code   <= in_chan.char_code;
      item_r.end_of_text <= in_chan.end_of_text;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;
endmodule

// ===== src/b64d_decode.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_decode
// Quartet state and decode logic: maps the held character, updates the
// quartet and error state and builds the group of results it causes.
// ----------------------------------------------------------------------------
module b64d_decode #(
  parameter int COUNT_BITS = 16
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      item_valid,
  input  b64d_pkg::in_item_t        item,
  input  logic [b64d_pkg::CNT_W-1:0] capacity,
  input  logic                      batch_done,
  output logic                      take,
  output logic                      load,
  output b64d_pkg::batch_t          batch
);
  import b64d_pkg::*;

  localparam int W = (COUNT_BITS > CNT_W) ? COUNT_BITS : CNT_W;
  localparam logic [W-1:0] CMAX = W'({COUNT_BITS{1'b1}});

  // Quartet and string state
  logic [1:0]            gp_r, gp_nxt;
  logic [2:0][5:0]       sx_r, sx_nxt;
  logic [2:0]            vc_r, vc_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [COUNT_BITS-1:0] emit_r, emit_nxt;

  logic [7:0]            sx;
  logic [5:0]            six;
  logic                  is_ws;
  logic [2:0]            vc_new;
  logic                  do_emit;
  logic [3:0][5:0]       q;
  logic [2:0]            qv;
  logic [1:0]            n_req;
  logic [1:0]            n_out;
  logic                  ovf;
  logic [CNT_W-1:0]      lim16;
  logic [W-1:0]          lim_w;
  logic [W-1:0]          emit_w;
  logic [W-1:0]          room;
  logic [2:0][7:0]       b;
  logic [2:0][CNT_W-1:0] cnt;
  logic [CNT_W-1:0]      fin_cnt;
  logic [1:0]            fin_status;
  logic [2:0]            k;

  // Zero-extend or truncate a count to the result field
  function automatic logic [CNT_W-1:0] to_field(input logic [COUNT_BITS-1:0] x);
    logic [W-1:0] t;
    t = W'(x);
    return t[CNT_W-1:0];
  endfunction

  assign sx    = sextet_of(item.char_code);
  assign six   = (sx == SX_PAD) ? 6'd0 : sx[5:0];
  assign is_ws = (item.char_code == CH_CR) || (item.char_code == CH_LF) ||
                 (item.char_code == CH_SPACE);

  // Next state and quartet selection
  always_comb begin
    gp_nxt   = gp_r;
    sx_nxt   = sx_r;
    vc_nxt   = vc_r;
    err_nxt  = err_r;
    do_emit  = 1'b0;
    q        = '0;
    qv       = vc_r;
    vc_new   = (sx == SX_PAD) ? vc_r : {1'b0, gp_r} + 3'd1;
    if (item.end_of_text) begin
      // flush a partial quartet, then clear the string
      if (err_r == ST_OK && gp_r != 2'd0) begin
        do_emit = 1'b1;
        q[0]    = sx_r[0];
        q[1]    = (gp_r > 2'd1) ? sx_r[1] : 6'd0;
        q[2]    = (gp_r > 2'd2) ? sx_r[2] : 6'd0;
      end
      gp_nxt  = 2'd0;
      sx_nxt  = '0;
      vc_nxt  = 3'd0;
      err_nxt = ST_OK;
    end else if (err_r != ST_OK) begin
      // swallow until the end marker
    end else if (gp_r == 2'd0 && is_ws) begin
      // skip whitespace between quartets
    end else if (sx == SX_BAD) begin
      err_nxt = ST_INVALID;
      gp_nxt  = 2'd0;
      sx_nxt  = '0;
      vc_nxt  = 3'd0;
    end else if (gp_r != 2'd3) begin
      sx_nxt[gp_r] = six;
      gp_nxt       = gp_r + 2'd1;
      vc_nxt       = vc_new;
    end else begin
      do_emit = 1'b1;
      q[0]    = sx_r[0];
      q[1]    = sx_r[1];
      q[2]    = sx_r[2];
      q[3]    = six;
      qv      = vc_new;
      gp_nxt  = 2'd0;
      sx_nxt  = '0;
      vc_nxt  = 3'd0;
    end
  end

  // Bytes of the quartet
  assign b[0] = {q[0], q[1][5:4]};
  assign b[1] = {q[1][3:0], q[2][5:2]};
  assign b[2] = {q[2][1:0], q[3]};

  // Bytes requested, trimmed by the room left under the limit
  assign n_req  = (do_emit && qv >= 3'd2) ? 2'(qv - 3'd1) : 2'd0;
  assign lim16  = capacity - CNT_W'(1);
  assign lim_w  = (W'(lim16) > CMAX) ? CMAX : W'(lim16);
  assign emit_w = W'(emit_r);
  assign room   = (emit_w < lim_w) ? (lim_w - emit_w) : '0;
  assign ovf    = room < W'(n_req);
  assign n_out  = ovf ? room[1:0] : n_req;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cnt[i] = to_field(emit_r + COUNT_BITS'(i + 1));
    end
  end

  assign fin_cnt    = to_field(emit_r + COUNT_BITS'(n_out));
  assign fin_status = ovf ? ST_OVERFLOW : err_r;
  assign k          = {1'b0, n_out} + {2'b0, item.end_of_text};

  // Take the request when it causes no result or the drain has room
  assign take = item_valid && (k == 3'd0 || batch_done);
  assign load = take && (k != 3'd0);

  // Build the result group
  always_comb begin
    batch     = '0;
    batch.cnt = k;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < n_out) begin
        batch.slot[i].data_byte  = b[i];
        batch.slot[i].status     = ST_OK;
        batch.slot[i].byte_count = cnt[i];
        batch.slot[i].last       = 1'b0;
      end
    end
    if (item.end_of_text) begin
      batch.slot[n_out].data_byte  = 8'd0;
      batch.slot[n_out].status     = fin_status;
      batch.slot[n_out].byte_count = fin_cnt;
      batch.slot[n_out].last       = 1'b1;
    end
  end

  // Emitted count advances by bytes sent and clears at the end marker
  assign emit_nxt = item.end_of_text ? '0 : (emit_r + COUNT_BITS'(n_out));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gp_r   <= 2'd0;
      sx_r   <= '0;
      vc_r   <= 3'd0;
      err_r  <= ST_OK;
      emit_r <= '0;
    end else if (take) begin
      gp_r   <= gp_nxt;
      sx_r   <= sx_nxt;
      vc_r   <= vc_nxt;
      err_r  <= (ovf && !item.end_of_text) ? ST_OVERFLOW : err_nxt;
      emit_r <= emit_nxt;
    end
  end
endmodule

// ===== src/b64d_out_buf.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b64d_out_buf
// Result register: holds the group of results of one request and hands
// them to the result channel one per cycle while the channel is ready.
// ----------------------------------------------------------------------------
module b64d_out_buf (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  b64d_pkg::batch_t batch,
  output logic             batch_done,
  b64d_out_if.source       out_chan
);
  import b64d_pkg::*;

  res_item_t [SLOTS-1:0] slot_r;
  logic [2:0]            n_r;
  logic [1:0]            rd_r;
  logic                  pop;
  res_item_t             head;

  assign head       = slot_r[rd_r];
  assign pop        = out_chan.valid && out_chan.ready;
  assign batch_done = (n_r == 3'd0) || (n_r == 3'd1 && pop);

  // Drive the result channel from the head slot
  assign out_chan.valid      = (n_r != 3'd0);
  assign out_chan.data_byte  = head.data_byte;
  assign out_chan.status     = head.status;
  assign out_chan.byte_count = head.byte_count;
  assign out_chan.last       = head.last;

  // Load a new group or advance through the current one
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n_r  <= 3'd0;
      rd_r <= 2'd0;
    end else if (load) begin
      n_r  <= batch.cnt;
      rd_r <= 2'd0;
    end else if (pop) begin
      n_r  <= n_r - 3'd1;
      rd_r <= rd_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= batch.slot;
    end
  end
endmodule
